// ===== rtl/core/tlr_pkg.sv =====
`default_nettype none

package tlr_pkg;

    // Coordinate width and largest brush radius.
    localparam int COORD_BITS = 10;
    localparam int MAX_RADIUS = 3;

    localparam int THICK_W  = 4;
    localparam int COLOUR_W = 8;
    localparam int PIX_W    = 12;

    // Signed error term and its doubled form.
    localparam int ERR_W = COORD_BITS + 2;
    localparam int E2_W  = ERR_W + 1;

    localparam int RAD_W = (MAX_RADIUS < 2) ? 1 : $clog2(MAX_RADIUS + 1);
    localparam int IDX_W = $clog2(2 * MAX_RADIUS + 2);

    // Width used to form a pixel coordinate before it is cut to PIX_W bits.
    localparam int PIX_SUM_W = (COORD_BITS + 2 > PIX_W) ? COORD_BITS + 2 : PIX_W;

    localparam int IN_FIELDS_W = 4 * COORD_BITS + THICK_W + COLOUR_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * PIX_W + COLOUR_W + 7) / 8) * 8;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_EMIT  = 2'd2
    } ctl_state_t;

    typedef struct packed
    {
        logic load_line;
        logic setup_err;
        logic do_step;
        logic emit_pixel;
    } tlr_cmd_t;

    typedef struct packed
    {
        logic line_active;
        logic last_pixel;
        logic out_free;
    } tlr_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlr_ctrl.sv =====
`default_nettype none

module tlr_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire tlr_pkg::op_t         in_op,
    output logic                      in_ready,
    input  wire tlr_pkg::tlr_status_t status,
    output tlr_pkg::tlr_cmd_t         cmd
);
    import tlr_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_START)
                    begin
                        state_next = ST_SETUP;
                    end
                    else if (status.line_active)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SETUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.last_pixel)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The input is always ready in the idle state, so a valid beat there is accepted.
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load_line  = 1'b0;
        cmd.setup_err  = 1'b0;
        cmd.do_step    = 1'b0;
        cmd.emit_pixel = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_line = in_valid && (in_op == OP_START);
                cmd.do_step   = in_valid && (in_op == OP_STEP) && status.line_active;
            end
            ST_SETUP:
            begin
                cmd.setup_err = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_pixel = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlr_datapath.sv =====
`default_nettype none

module tlr_datapath
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tlr_pkg::tlr_cmd_t                cmd,
    output tlr_pkg::tlr_status_t                  status,
    input  wire logic [tlr_pkg::COORD_BITS-1:0]   start_x,
    input  wire logic [tlr_pkg::COORD_BITS-1:0]   start_y,
    input  wire logic [tlr_pkg::COORD_BITS-1:0]   end_x,
    input  wire logic [tlr_pkg::COORD_BITS-1:0]   end_y,
    input  wire logic [tlr_pkg::THICK_W-1:0]      line_thickness,
    input  wire logic [tlr_pkg::COLOUR_W-1:0]     line_colour,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic signed [tlr_pkg::PIX_W-1:0]      pix_x,
    output logic signed [tlr_pkg::PIX_W-1:0]      pix_y,
    output logic [tlr_pkg::COLOUR_W-1:0]          pix_colour,
    output logic                                  square_last,
    output logic                                  at_line_end
);
    import tlr_pkg::*;

    logic [COORD_BITS-1:0]   cur_x_reg,    cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg,    cur_y_next;
    logic [COORD_BITS-1:0]   target_x_reg;
    logic [COORD_BITS-1:0]   target_y_reg;
    logic [COORD_BITS-1:0]   delta_x_reg;
    logic [COORD_BITS-1:0]   delta_y_reg;
    logic                    dir_x_neg_reg;
    logic                    dir_y_neg_reg;
    logic signed [ERR_W-1:0] err_reg,      err_next;
    logic [RAD_W-1:0]        radius_reg;
    logic [COLOUR_W-1:0]     colour_reg;
    logic                    active_reg;
    logic [IDX_W-1:0]        ix_reg;
    logic [IDX_W-1:0]        iy_reg;
    logic                    out_valid_reg;
    logic signed [PIX_W-1:0] pix_x_reg;
    logic signed [PIX_W-1:0] pix_y_reg;
    logic [COLOUR_W-1:0]     pix_colour_reg;
    logic                    square_last_reg;
    logic                    at_end_reg;

    logic                    x_lt;
    logic                    y_lt;
    logic [THICK_W-2:0]      half_thick;
    logic [RAD_W-1:0]        radius_in;
    logic signed [E2_W-1:0]  e2;
    logic signed [E2_W-1:0]  neg_dy;
    logic signed [E2_W-1:0]  pos_dx;
    logic                    x_go;
    logic                    y_go;
    logic [IDX_W-1:0]        span;
    logic                    last_col;
    logic                    last_row;
    logic                    at_end;
    logic                    out_free;
    logic signed [PIX_SUM_W-1:0] px_sum;
    logic signed [PIX_SUM_W-1:0] py_sum;

    assign x_lt       = start_x < end_x;
    assign y_lt       = start_y < end_y;
    assign half_thick = line_thickness[THICK_W-1:1];
    assign radius_in  = (half_thick > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                  : RAD_W'(half_thick);

    // Standard signed Bresenham decision on the doubled error.
    assign e2     = {err_reg, 1'b0};
    assign neg_dy = -$signed(E2_W'(delta_y_reg));
    assign pos_dx = $signed(E2_W'(delta_x_reg));
    assign x_go   = e2 >= neg_dy;
    assign y_go   = e2 <= pos_dx;

    always_comb
    begin
        err_next   = err_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (x_go)
        begin
            err_next   = err_next - $signed(ERR_W'(delta_y_reg));
            cur_x_next = dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        end
        if (y_go)
        begin
            err_next   = err_next + $signed(ERR_W'(delta_x_reg));
            cur_y_next = dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        end
    end

    assign span     = IDX_W'({radius_reg, 1'b0});
    assign last_col = ix_reg == span;
    assign last_row = iy_reg == span;
    assign at_end   = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign px_sum = $signed(PIX_SUM_W'(cur_x_reg)) + $signed(PIX_SUM_W'(ix_reg))
                    - $signed(PIX_SUM_W'(radius_reg));
    assign py_sum = $signed(PIX_SUM_W'(cur_y_reg)) + $signed(PIX_SUM_W'(iy_reg))
                    - $signed(PIX_SUM_W'(radius_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            err_reg       <= '0;
            radius_reg    <= '0;
            colour_reg    <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_line)
            begin
                cur_x_reg     <= start_x;
                cur_y_reg     <= start_y;
                target_x_reg  <= end_x;
                target_y_reg  <= end_y;
                dir_x_neg_reg <= !x_lt;
                dir_y_neg_reg <= !y_lt;
                delta_x_reg   <= x_lt ? end_x - start_x : start_x - end_x;
                delta_y_reg   <= y_lt ? end_y - start_y : start_y - end_y;
                radius_reg    <= radius_in;
                colour_reg    <= line_colour;
                active_reg    <= 1'b1;
            end
            if (cmd.setup_err)
            begin
                err_reg <= $signed(ERR_W'(delta_x_reg)) - $signed(ERR_W'(delta_y_reg));
            end
            if (cmd.do_step)
            begin
                err_reg   <= err_next;
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
            end
            // The line is finished once the square on the endpoint is out.
            if (cmd.emit_pixel && last_col && last_row && at_end)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // Brush scan counters and the output beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg        <= '0;
            iy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit_pixel)
            begin
                out_valid_reg <= 1'b1;
                if (last_col)
                begin
                    ix_reg <= '0;
                    iy_reg <= last_row ? '0 : iy_reg + 1'b1;
                end
                else
                begin
                    ix_reg <= ix_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pixel)
        begin
            pix_x_reg       <= px_sum[PIX_W-1:0];
            pix_y_reg       <= py_sum[PIX_W-1:0];
            pix_colour_reg  <= colour_reg;
            square_last_reg <= last_col && last_row;
            at_end_reg      <= at_end;
        end
    end

    assign status.line_active = active_reg;
    assign status.last_pixel  = last_col && last_row;
    assign status.out_free    = out_free;

    assign out_valid   = out_valid_reg;
    assign pix_x       = pix_x_reg;
    assign pix_y       = pix_y_reg;
    assign pix_colour  = pix_colour_reg;
    assign square_last = square_last_reg;
    assign at_line_end = at_end_reg;

endmodule

`default_nettype wire

// ===== rtl/core/thick_line_rasterizer_unit.sv =====
`default_nettype none

// Channel   Direction  tdata                                   tuser        tlast
// s_axis    in         start/end points, thickness, colour     op           -
// m_axis    out        pix_x, pix_y, pix_colour                at_line_end  square_last
//
// A start beat is accepted, then the error term is formed, then one brush pixel
// per cycle goes to the single output register unless m_axis_tready stalls; a
// step beat is accepted with its step, then its pixels follow alike. An item has
// (2r+1)^2 pixels, at most a 7 by 7 brush, from the brush scan counter.
// Reset (rst_n, asynchronous, active low) leaves no line loaded.
// A stall on m_axis_tready holds the scan; s_axis_tready rises again once the
// last pixel of a square sits in the output register.
module thick_line_rasterizer_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // start_x, start_y, end_x, end_y, line_thickness, line_colour, zero pad
    input  wire logic [tlr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // pix_x, pix_y, pix_colour
    output logic [tlr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // at_line_end
    output logic                                  m_axis_tuser,
    // square_last
    output logic                                  m_axis_tlast
);
    import tlr_pkg::*;

    localparam int SX_LO  = 0;
    localparam int SY_LO  = COORD_BITS;
    localparam int EX_LO  = 2 * COORD_BITS;
    localparam int EY_LO  = 3 * COORD_BITS;
    localparam int TH_LO  = 4 * COORD_BITS;
    localparam int COL_LO = TH_LO + THICK_W;

    tlr_cmd_t                cmd;
    tlr_status_t             status;
    op_t                     in_op;
    logic signed [PIX_W-1:0] pix_x;
    logic signed [PIX_W-1:0] pix_y;
    logic [COLOUR_W-1:0]     pix_colour;

    assign in_op = op_t'(s_axis_tuser);

    tlr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (in_op),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlr_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .start_x        (s_axis_tdata[SX_LO +: COORD_BITS]),
        .start_y        (s_axis_tdata[SY_LO +: COORD_BITS]),
        .end_x          (s_axis_tdata[EX_LO +: COORD_BITS]),
        .end_y          (s_axis_tdata[EY_LO +: COORD_BITS]),
        .line_thickness (s_axis_tdata[TH_LO +: THICK_W]),
        .line_colour    (s_axis_tdata[COL_LO +: COLOUR_W]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .pix_x          (pix_x),
        .pix_y          (pix_y),
        .pix_colour     (pix_colour),
        .square_last    (m_axis_tlast),
        .at_line_end    (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'({pix_colour, pix_y, pix_x});

endmodule

`default_nettype wire
